### design/rslp_pkg.sv
package rslp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LH    = 8'h68;

  localparam logic [3:0] TEN_MINUS_A = 4'd10;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_BAD = 2'd3
  } radix_t;

  typedef logic [VALUE_BITS-1:0] acc_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    radix_t                     kind;
  } result_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [2:0] digit_class(input logic [7:0] c);
    logic [2:0] m;
    m = 3'b000;
    if (is_dec(c)) m = m | 3'b101;
    if ((c == CH_ZERO) || (c == CH_ONE)) m = m | 3'b010;
    if (((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LF))) m = m | 3'b100;
    return m;
  endfunction

  function automatic logic [3:0] dec_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return is_dec(c) ? d[3:0] : 4'd0;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (is_dec(c)) d = c - CH_ZERO;
    else if ((c >= CH_UA) && (c <= CH_UF)) d = c - CH_UA + 8'(TEN_MINUS_A);
    else if ((c >= CH_LA) && (c <= CH_LF)) d = c - CH_LA + 8'(TEN_MINUS_A);
    return d[3:0];
  endfunction

  function automatic acc_t dec_step(input acc_t s, input logic [7:0] c);
    return (s << 3) + (s << 1) + VALUE_BITS'(dec_value(c));
  endfunction

  function automatic acc_t bin_step(input acc_t s, input logic [7:0] c);
    return {s[VALUE_BITS-2:0], c[0]};
  endfunction

  function automatic acc_t hex_step(input acc_t s, input logic [7:0] c);
    return {s[VALUE_BITS-5:0], hex_value(c)};
  endfunction

  function automatic logic [OUT_BITS-1:0] finish_value(input acc_t s, input logic neg);
    acc_t        v;
    logic [63:0] ext;
    v   = neg ? (VALUE_BITS'(0) - s) : s;
    ext = 64'(signed'(v));
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

### design/radix_suffix_literal_parser_top.sv
// Parses an assembler number literal whose base is given by a trailing suffix.
// The input channel carries one ASCII character per item on in_symbol, with
// in_last high on the final character of the literal. A leading minus sign
// negates the value; a final d/D, b/B or h/H selects decimal, binary or
// hexadecimal, and any other final character is a decimal digit.
// The output channel carries one item per literal: out_value, a wrapping
// 32-bit two's-complement value, and out_radix_kind (0 decimal, 1 binary,
// 2 hexadecimal, 3 invalid with a value of zero).
// One character is accepted in every cycle while in_stall is low. The result
// appears on the output register in the cycle after the final character is
// accepted; the decimal, binary and hexadecimal accumulators run side by side,
// so the base does not delay the result.
// Reset is synchronous and active low; it empties the output register and
// starts a new literal.
// While out_stall holds a waiting result, in_stall is raised and the result
// stays unchanged; otherwise a new character is taken even as the result
// leaves.
module radix_suffix_literal_parser_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_symbol,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rslp_pkg::OUT_BITS-1:0] out_value,
  output logic [1:0]                           out_radix_kind
);
  import rslp_pkg::*;

  logic    take;
  logic    fire;
  logic    busy;
  result_t result;

  assign in_stall = busy;
  assign take     = in_valid && !busy;

  rslp_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .symbol (in_symbol),
    .last   (in_last),
    .fire   (fire),
    .result (result)
  );

  rslp_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (fire),
    .result         (result),
    .out_stall      (out_stall),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_radix_kind (out_radix_kind)
  );

endmodule

### design/rslp_accum.sv
module rslp_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        symbol,
  input  logic              last,
  output logic              fire,
  output rslp_pkg::result_t result
);
  import rslp_pkg::*;

  logic       at_start_r, at_start_nxt;
  logic       negative_r, negative_nxt;
  acc_t       dec_sum_r, dec_sum_nxt;
  acc_t       bin_sum_r, bin_sum_nxt;
  acc_t       hex_sum_r, hex_sum_nxt;
  logic [2:0] lead_ok_r, lead_ok_nxt;
  logic [2:0] body_ok_r, body_ok_nxt;

  logic [2:0] cls;
  logic       is_minus;
  acc_t       dec_base, bin_base, hex_base;
  acc_t       dec_acc, bin_acc, hex_acc;
  acc_t       sel_sum;
  logic [2:0] body_fin;
  logic [2:0] ok_mask;
  radix_t     kind;

  assign fire = take && last;

  always_comb begin
    cls      = digit_class(symbol);
    is_minus = (symbol == CH_MINUS);
    dec_base = at_start_r ? '0 : dec_sum_r;
    bin_base = at_start_r ? '0 : bin_sum_r;
    hex_base = at_start_r ? '0 : hex_sum_r;
    dec_acc  = dec_step(dec_base, symbol);
    bin_acc  = bin_step(bin_base, symbol);
    hex_acc  = hex_step(hex_base, symbol);

    body_fin = body_ok_r;
    kind     = RADIX_DEC;
    sel_sum  = dec_acc;
    case (symbol)
      CH_LD, CH_UD: begin
        kind    = RADIX_DEC;
        sel_sum = dec_sum_r;
      end
      CH_LB, CH_UB: begin
        kind    = RADIX_BIN;
        sel_sum = bin_sum_r;
      end
      CH_LH, CH_UH: begin
        kind    = RADIX_HEX;
        sel_sum = hex_sum_r;
      end
      default: begin
        kind     = RADIX_DEC;
        sel_sum  = dec_acc;
        body_fin = body_ok_r & cls;
      end
    endcase
    ok_mask = lead_ok_r & body_fin;

    if (at_start_r) begin
      if (is_minus) begin
        result.value = '0;
        result.kind  = RADIX_DEC;
      end else if (is_dec(symbol)) begin
        result.value = finish_value(dec_acc, 1'b0);
        result.kind  = RADIX_DEC;
      end else begin
        result.value = '0;
        result.kind  = RADIX_BAD;
      end
    end else if (ok_mask[kind]) begin
      result.value = finish_value(sel_sum, negative_r);
      result.kind  = kind;
    end else begin
      result.value = '0;
      result.kind  = RADIX_BAD;
    end

    at_start_nxt = at_start_r;
    negative_nxt = negative_r;
    dec_sum_nxt  = dec_sum_r;
    bin_sum_nxt  = bin_sum_r;
    hex_sum_nxt  = hex_sum_r;
    lead_ok_nxt  = lead_ok_r;
    body_ok_nxt  = body_ok_r;
    if (take) begin
      if (last) begin
        at_start_nxt = 1'b1;
        negative_nxt = 1'b0;
        dec_sum_nxt  = '0;
        bin_sum_nxt  = '0;
        hex_sum_nxt  = '0;
        lead_ok_nxt  = 3'b000;
        body_ok_nxt  = 3'b111;
      end else if (at_start_r) begin
        at_start_nxt = 1'b0;
        negative_nxt = is_minus;
        lead_ok_nxt  = is_minus ? 3'b111 : cls;
        body_ok_nxt  = 3'b111;
        dec_sum_nxt  = is_minus ? '0 : dec_acc;
        bin_sum_nxt  = is_minus ? '0 : bin_acc;
        hex_sum_nxt  = is_minus ? '0 : hex_acc;
      end else begin
        body_ok_nxt = body_ok_r & cls;
        dec_sum_nxt = dec_acc;
        bin_sum_nxt = bin_acc;
        hex_sum_nxt = hex_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      negative_r <= 1'b0;
      dec_sum_r  <= '0;
      bin_sum_r  <= '0;
      hex_sum_r  <= '0;
      lead_ok_r  <= 3'b000;
      body_ok_r  <= 3'b111;
    end else begin
      at_start_r <= at_start_nxt;
      negative_r <= negative_nxt;
      dec_sum_r  <= dec_sum_nxt;
      bin_sum_r  <= bin_sum_nxt;
      hex_sum_r  <= hex_sum_nxt;
      lead_ok_r  <= lead_ok_nxt;
      body_ok_r  <= body_ok_nxt;
    end
  end

endmodule

### design/rslp_out_reg.sv
module rslp_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  rslp_pkg::result_t               result,
  input  logic                            out_stall,
  output logic                            busy,
  output logic                            out_valid,
  output logic signed [rslp_pkg::OUT_BITS-1:0] out_value,
  output logic [1:0]                      out_radix_kind
);
  import rslp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign busy           = valid_r && out_stall;
  assign out_valid      = valid_r;
  assign out_value      = data_r.value;
  assign out_radix_kind = data_r.kind;

  always_comb begin
    valid_nxt = load ? 1'b1 : busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

### design/rslp_checker.sv
module rslp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_last,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [rslp_pkg::OUT_BITS-1:0] out_value,
  input logic [1:0]                           out_radix_kind
);
  import rslp_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_radix_kind))
    else $error("Stalled result item changed.");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_radix_kind == RADIX_BAD) |-> (out_value == '0))
    else $error("Invalid literal gave a nonzero value.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled with no result waiting.");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> out_valid)
    else $error("Final character gave no result item.");

endmodule

bind radix_suffix_literal_parser_top rslp_checker u_rslp_checker (.*);

### tb/radix_suffix_literal_parser_top_test.sv
module radix_suffix_literal_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rslp_pkg::*;

  typedef struct packed {
    logic [7:0]         sym;
    logic               lst;
    logic               typed;
    logic signed [31:0] val;
    radix_t             kind;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_symbol = 8'h00;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]         out_radix_kind;

  radix_suffix_literal_parser_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_radix_kind (out_radix_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Literal parser state as seen from outside.
  bit          lit_fresh = 1'b1;
  bit          lit_neg;
  logic [7:0]  held_sym;
  bit          held_valid;
  logic [31:0] dec_acc;
  logic [31:0] bin_acc;
  logic [31:0] hex_acc;
  logic [2:0]  lead_mask;
  logic [2:0]  body_mask = 3'b111;

  result_t   expected_results[$];
  stim_row_t plan[$];
  int        failures;
  int        sent_items;
  int        stall_left;
  bit        calm;

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (is_digit(c)) return c[3:0];
    if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF))) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic logic [2:0] digit_mask(input logic [7:0] c);
    logic [2:0] m;
    m[0] = is_digit(c);
    m[1] = (c == CH_ZERO) || (c == CH_ONE);
    m[2] = is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic absorb(input logic [7:0] c);
    dec_acc = dec_acc * 32'd10 + (is_digit(c) ? 32'(c[3:0]) : 32'd0);
    bin_acc = {bin_acc[30:0], c[0]};
    hex_acc = {hex_acc[27:0], hex_nibble(c)};
  endtask

  task automatic clear_literal();
    lit_fresh  = 1'b1;
    lit_neg    = 1'b0;
    held_sym   = 8'h00;
    held_valid = 1'b0;
    dec_acc    = '0;
    bin_acc    = '0;
    hex_acc    = '0;
    lead_mask  = 3'b000;
    body_mask  = 3'b111;
  endtask

  task automatic predict_symbol(input logic [7:0] c, input logic lst, output bit produced,
                                output result_t res);
    radix_t      k;
    logic [31:0] v;
    logic [2:0]  ok_mask;
    produced = 1'b0;
    res = '0;
    if (lit_fresh) begin
      if (lst) begin
        produced = 1'b1;
        if (c == CH_MINUS) begin
          res.kind = RADIX_DEC;
        end else if (is_digit(c)) begin
          res.value = 32'(c[3:0]);
          res.kind = RADIX_DEC;
        end else begin
          res.kind = RADIX_BAD;
        end
        clear_literal();
      end else begin
        clear_literal();
        lit_fresh = 1'b0;
        if (c == CH_MINUS) begin
          lit_neg = 1'b1;
          lead_mask = 3'b111;
        end else begin
          lead_mask = digit_mask(c);
          absorb(c);
        end
      end
    end else begin
      if (held_valid) begin
        body_mask = body_mask & digit_mask(held_sym);
        absorb(held_sym);
        held_valid = 1'b0;
      end
      if (!lst) begin
        held_sym = c;
        held_valid = 1'b1;
      end else begin
        case (c)
          CH_LD, CH_UD: k = RADIX_DEC;
          CH_LB, CH_UB: k = RADIX_BIN;
          CH_LH, CH_UH: k = RADIX_HEX;
          default: begin
            body_mask = body_mask & digit_mask(c);
            absorb(c);
            k = RADIX_DEC;
          end
        endcase
        ok_mask = lead_mask & body_mask;
        produced = 1'b1;
        if (ok_mask[k]) begin
          v = (k == RADIX_DEC) ? dec_acc : (k == RADIX_BIN) ? bin_acc : hex_acc;
          if (lit_neg) v = -v;
          res.value = v;
          res.kind = k;
        end else begin
          res.kind = RADIX_BAD;
        end
        clear_literal();
      end
    end
  endtask

  task automatic send_symbol(input stim_row_t r);
    int      gap;
    bit      produced;
    result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_symbol <= r.sym;
    in_last <= r.lst;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_symbol(r.sym, r.lst, produced, res);
    if (produced) begin
      if (r.typed) begin
        res.value = r.val;
        res.kind = r.kind;
      end
      expected_results.push_back(res);
    end
    sent_items++;
  endtask

  task automatic add_row(input logic [7:0] sym, input logic lst, input logic typed,
                         input logic signed [31:0] val, input radix_t kind);
    stim_row_t r;
    r.sym = sym;
    r.lst = lst;
    r.typed = typed;
    r.val = val;
    r.kind = kind;
    plan.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic random_literal();
    logic [7:0] chars[$];
    int         style;
    int         base;
    int         ndig;
    int         d;
    int         r;
    stim_row_t  row;
    style = $urandom_range(0, 99);
    if (style < 15) begin
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      base = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) chars.push_back(CH_MINUS);
      r = $urandom_range(0, 9);
      if (r == 0) ndig = 0;
      else if (r < 7) ndig = $urandom_range(1, 4);
      else ndig = (base == 1) ? $urandom_range(5, 40) : $urandom_range(5, 12);
      repeat (ndig) begin
        case (base)
          0: chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          1: chars.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
          default: begin
            d = $urandom_range(0, 21);
            if (d < 10) chars.push_back(CH_ZERO + 8'(d));
            else if (d < 16) chars.push_back(CH_LA + 8'(d - 10));
            else chars.push_back(CH_UA + 8'(d - 16));
          end
        endcase
      end
      case (base)
        0: begin
          r = $urandom_range(0, 2);
          if (r == 1) chars.push_back(CH_LD);
          else if (r == 2) chars.push_back(CH_UD);
          else if (chars.size() == 0) chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        1: chars.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
        default: chars.push_back($urandom_range(0, 1) ? CH_LH : CH_UH);
      endcase
      if (style < 25) chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (chars[i]) begin
      row = '0;
      row.sym = chars[i];
      row.lst = (i == chars.size() - 1);
      send_symbol(row);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: value %0d kind %0d", out_value, out_radix_kind);
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value || out_radix_kind !== want.kind) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: value expected %0d actual %0d, kind expected %0d actual %0d",
                     want.value, out_value, want.kind, out_radix_kind);
        end
      end
    end
  end

  initial begin
    int lit_count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_row("9", 1'b1, 1'b1, 9, RADIX_DEC);
    add_row(CH_MINUS, 1'b1, 1'b1, 0, RADIX_DEC);
    add_row(CH_LH, 1'b1, 1'b1, 0, RADIX_BAD);
    add_row(8'hFF, 1'b1, 1'b1, 0, RADIX_BAD);
    add_row(CH_MINUS, 1'b0, 1'b0, 0, RADIX_DEC);
    add_row(CH_UD, 1'b1, 1'b1, 0, RADIX_DEC);
    add_row(CH_MINUS, 1'b0, 1'b0, 0, RADIX_DEC);
    add_row(CH_LB, 1'b1, 1'b1, 0, RADIX_BIN);
    add_row(CH_MINUS, 1'b0, 1'b0, 0, RADIX_DEC);
    add_row(CH_UH, 1'b1, 1'b1, 0, RADIX_HEX);
    repeat (8) add_row(CH_UF, 1'b0, 1'b0, 0, RADIX_DEC);
    add_row(CH_LH, 1'b1, 1'b1, -1, RADIX_HEX);
    add_row(CH_MINUS, 1'b0, 1'b0, 0, RADIX_DEC);
    add_row("5", 1'b1, 1'b1, -5, RADIX_DEC);
    add_row("1", 1'b0, 1'b0, 0, RADIX_DEC);
    add_row("0", 1'b0, 1'b0, 0, RADIX_DEC);
    add_row(CH_UB, 1'b1, 1'b0, 0, RADIX_DEC);
    add_row(8'h00, 1'b0, 1'b0, 0, RADIX_DEC);
    add_row("7", 1'b1, 1'b0, 0, RADIX_DEC);

    foreach (plan[i]) send_symbol(plan[i]);
    wait_drained();

    lit_count = 0;
    while (sent_items < 550) begin
      if (lit_count % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      if (lit_count == 40) wait_drained();
      random_literal();
      lit_count++;
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
